[design/fpdf_pkg.sv]
// Package for the fixed-point decimal formatter.
// Holds the transaction payload structs, field widths and ASCII constants.
// No dependencies.
package fpdf_pkg;

    localparam int FD_W   = 3;   // fraction_digits register width
    localparam int MAG_W  = 32;  // magnitude field width
    localparam int CHAR_W = 7;   // ASCII character width

    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

    // Input transaction
    typedef struct packed {
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } fpdf_in_t;

    // Result transaction, one per character
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } fpdf_out_t;

endpackage

[design/fpdf_bcd_step.sv]
// One shift-and-add-3 step of the binary to BCD conversion.
// Shared unit used once per cycle by the formatter sequencer. Uses fpdf_pkg.
module fpdf_bcd_step
    import fpdf_pkg::*;
#(
    parameter int NDIG       = 10,
    parameter int VALUE_BITS = 32
) (
    input  logic [NDIG*4-1:0]     bcd_i,
    input  logic [VALUE_BITS-1:0] bin_i,
    output logic [NDIG*4-1:0]     bcd_o,
    output logic [VALUE_BITS-1:0] bin_o
);

    logic [NDIG*4-1:0] adj;

    // Add 3 to every digit of 5 or more, digits are independent
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_i[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = bcd_i[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = bcd_i[i*4 +: 4];
            end
        end
    end

    // Shift the binary MSB into the BCD word
    assign bcd_o = {adj[NDIG*4-2:0], bin_i[VALUE_BITS-1]};
    assign bin_o = {bin_i[VALUE_BITS-2:0], 1'b0};

endmodule

[design/fixed_point_decimal_formatter_top.sv]
// Fixed-point decimal formatter, top level: sequencer, registers, config.
// Uses fpdf_pkg and the shared conversion unit fpdf_bcd_step.
//
// Accepts one transaction (sign flag and magnitude scaled by ten to the power
// fraction_digits) and emits its decimal text one ASCII character per result
// transaction, most significant first, with last flagged on the final one.
// A value is accepted, then converted by VALUE_BITS shift-and-add-3 steps
// through the single BCD step unit, then the NPOS digit positions are walked
// (suppressed leading zero or emitted digit), with the sign and the point
// emitted when present; emission waits while the result side stalls. s_ready
// is high only between values; the final character may still wait in the
// output register while the next value is accepted. The user must write
// fraction_digits via cfg_we/cfg_wdata only while idle; the block itself does
// not enforce this. Values above MAX_FRACTION_DIGITS act as the maximum.
module fixed_point_decimal_formatter_top
    import fpdf_pkg::*;
#(
    parameter int VALUE_BITS          = 32,
    parameter int MAX_FRACTION_DIGITS = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [FD_W-1:0] cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  fpdf_in_t        s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output fpdf_out_t       m_data
);

    // Decimal digits needed for VALUE_BITS bits, and positions to walk
    localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NPOS  = (NDIG > MAX_FRACTION_DIGITS + 1) ? NDIG
                                                            : MAX_FRACTION_DIGITS + 1;
    localparam int POS_W = $clog2(NPOS);
    localparam int FR_W  = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SIGN  = 5'b00100,
        ST_DIGIT = 5'b01000,
        ST_POINT = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [FD_W-1:0]       fd_reg, fd_next;
    logic [FR_W-1:0]       fr_reg, fr_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [NDIG*4-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  started_reg, started_next;
    logic                  m_valid_reg, m_valid_next;
    fpdf_out_t             m_data_reg, m_data_next;

    logic [NDIG*4-1:0]     step_bcd;
    logic [VALUE_BITS-1:0] step_bin;
    logic [3:0]            digit;
    logic                  out_free;
    logic                  emit;
    fpdf_out_t             emit_data;

    // Shared conversion step
    fpdf_bcd_step #(
        .NDIG       (NDIG),
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .bcd_i (bcd_reg),
        .bin_i (bin_reg),
        .bcd_o (step_bcd),
        .bin_o (step_bin)
    );

    // Digit at the current position; positions above the BCD word read as 0
    always_comb begin
        if (int'(pos_reg) < NDIG) begin
            digit = bcd_reg[pos_reg*4 +: 4];
        end else begin
            digit = 4'd0;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        fd_next      = fd_reg;
        fr_next      = fr_reg;
        neg_next     = neg_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        emit         = 1'b0;
        emit_data    = '{character: CH_ZERO, last: 1'b0};

        if (cfg_we) begin
            fd_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next = s_data.negative;
                    bin_next = VALUE_BITS'(s_data.magnitude);
                    bcd_next = '0;
                    cnt_next = CNT_W'(VALUE_BITS);
                    if (int'(fd_reg) > MAX_FRACTION_DIGITS) begin
                        fr_next = FR_W'(MAX_FRACTION_DIGITS);
                    end else begin
                        fr_next = FR_W'(fd_reg);
                    end
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = step_bcd;
                bin_next = step_bin;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    pos_next     = POS_W'(NPOS - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_data  = '{character: CH_MINUS, last: 1'b0};
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                // Suppress leading zeros above the units position
                if (!started_reg && (int'(pos_reg) > int'(fr_reg)) && (digit == 4'd0)) begin
                    pos_next = pos_reg - POS_W'(1);
                end else if (out_free) begin
                    emit         = 1'b1;
                    emit_data    = '{character: CHAR_W'(CH_ZERO + {3'b000, digit}),
                                     last: (pos_reg == '0)};
                    started_next = 1'b1;
                    if ((fr_reg != '0) && (int'(pos_reg) == int'(fr_reg))) begin
                        state_next = ST_POINT;
                    end else if (pos_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg - POS_W'(1);
                    end
                end
            end
            ST_POINT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_data  = '{character: CH_POINT, last: 1'b0};
                    pos_next   = pos_reg - POS_W'(1);
                    state_next = ST_DIGIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fd_reg      <= FD_W'(2);
            m_valid_reg <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fd_reg      <= fd_next;
            m_valid_reg <= m_valid_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        fr_reg     <= fr_next;
        neg_reg    <= neg_next;
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        cnt_reg    <= cnt_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[design/fpdf_checker.sv]
// Port-level assertions for the fixed-point decimal formatter.
// Uses fpdf_pkg; bound to fixed_point_decimal_formatter_top below.
module fpdf_checker
    import fpdf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input fpdf_out_t m_data
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // Block is busy right after taking a value
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready straight after an input transaction");

    // Only sign, point and decimal digits are produced
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.character == CH_MINUS) || (m_data.character == CH_POINT) ||
                     ((m_data.character >= CH_ZERO) && (m_data.character <= CH_NINE))))
        else $error("illegal character");

    // A new value is not taken while its predecessor's text is unfinished
    a_text_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready)
        else $error("ready while text incomplete");

endmodule

bind fixed_point_decimal_formatter_top fpdf_checker u_fpdf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[sim/tb_top.sv]
// Self-checking testbench for the fixed-point decimal formatter top level.
// Predicts each value's character text and checks every result transaction.
// Depends on fpdf_pkg and fixed_point_decimal_formatter_top.
module tb_top;
    import fpdf_pkg::*;

    localparam int MAX_FD         = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 100;

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [FD_W-1:0] cfg_wdata = '0;
    logic            s_valid   = 1'b0;
    logic            s_ready;
    fpdf_in_t        s_data    = '0;
    logic            m_valid;
    logic            m_ready   = 1'b0;
    fpdf_out_t       m_data;

    // Predictor state and scoreboard
    bit [FD_W-1:0] frac_setting = 3'd2;
    fpdf_in_t      pending_values [$];
    fpdf_out_t     expected_chars [$];
    fpdf_out_t     wanted_char;
    logic          value_taken = 1'b0;
    int            errors = 0;
    int            values_accepted = 0;
    int            chars_checked = 0;
    int            settings_used = 1;
    int            quiet_cycles;

    // Idling controls; sequence sets rates and hold_asked at rising edges
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_asked     = 0;
    int            hold_taken     = 0;
    int            hold_left      = 0;

    fixed_point_decimal_formatter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic bit [31:0] pow10(input int k);
        bit [31:0] p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    // Decimal text of one value at the current fraction setting
    function automatic void predict_text(input fpdf_in_t item);
        bit [3:0]          digit_lsf [$];
        bit [CHAR_W-1:0]   text [$];
        bit [31:0]         rest;
        int                fr;
        fpdf_out_t         ch;
        rest = item.magnitude;
        fr = (frac_setting > MAX_FD) ? MAX_FD : int'(frac_setting);
        while (rest != 0) begin
            digit_lsf.push_back(4'(rest % 10));
            rest = rest / 10;
        end
        // at least one integer digit, zero-padded fraction
        while (digit_lsf.size() < fr + 1)
            digit_lsf.push_back(4'd0);
        if (item.negative)
            text.push_back(CH_MINUS);
        for (int pos = digit_lsf.size() - 1; pos >= 0; pos--) begin
            text.push_back(CH_ZERO + 7'(digit_lsf[pos]));
            if (fr > 0 && pos == fr)
                text.push_back(CH_POINT);
        end
        for (int i = 0; i < text.size(); i++) begin
            ch.character = text[i];
            ch.last      = (i == text.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // Random value, weighted towards short texts and unit boundaries
    function automatic fpdf_in_t random_value();
        fpdf_in_t v;
        int       kind;
        v.negative = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: v.magnitude = $urandom();
            4, 5, 6:    v.magnitude = $urandom_range(0, pow10($urandom_range(1, 6)));
            7:          v.magnitude = pow10($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
            8:          v.magnitude = '0;
            default:    v.magnitude = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
        return v;
    endfunction

    // Sender: one transaction held until accepted, random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !value_taken) begin
            s_valid <= 1'b1;
        end else if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            s_data  <= pending_values.pop_front();
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input acceptance, compare each result
    always @(posedge aclk) begin
        if (!aresetn) begin
            value_taken <= 1'b0;
        end else begin
            value_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                predict_text(s_data);
                values_accepted++;
            end
            if (m_valid && m_ready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character: expected none, got %h last %b",
                             $time, m_data.character, m_data.last);
                    errors++;
                end else begin
                    wanted_char = expected_chars.pop_front();
                    if (m_data.character !== wanted_char.character) begin
                        $display("%0t: character mismatch: expected %h, got %h",
                                 $time, wanted_char.character, m_data.character);
                        errors++;
                    end
                    if (m_data.last !== wanted_char.last) begin
                        $display("%0t: last mismatch: expected %b, got %b",
                                 $time, wanted_char.last, m_data.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("fixed_point_decimal_formatter_top test failed");
        $finish;
    end

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_values.size() != 0 || s_valid || expected_chars.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_frac_digits(input bit [FD_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        frac_setting = val;
        settings_used++;
        @(posedge aclk);
    endtask

    task automatic push_value(input bit neg, input bit [31:0] mag);
        fpdf_in_t v;
        v.negative  = neg;
        v.magnitude = mag;
        pending_values.push_back(v);
    endtask

    // One setting: boundary values first, then random values
    task automatic run_phase(input bit [FD_W-1:0] fd, input int idle_pct,
                             input int stall_pct, input int count, input bit long_hold);
        int fr;
        write_frac_digits(fd);
        fr = (fd > MAX_FD) ? MAX_FD : int'(fd);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        push_value(1'b1, 32'd0);
        push_value(1'b0, pow10(fr) - 1);
        push_value(1'b1, pow10(fr));
        push_value(1'b0, 32'hFFFF_FFFF);
        repeat (count) pending_values.push_back(random_value());
        if (long_hold)
            hold_asked++;
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed values at the reset setting of two fraction digits
        push_value(1'b0, 32'd0);
        push_value(1'b1, 32'd0);
        push_value(1'b0, 32'd1);
        push_value(1'b0, 32'd9);
        push_value(1'b1, 32'd10);
        push_value(1'b0, 32'd99);
        push_value(1'b0, 32'd100);
        push_value(1'b1, 32'd101);
        push_value(1'b1, 32'hFFFF_FFFF);
        push_value(1'b0, 32'hFFFF_FFFF);
        push_value(1'b0, 32'd1_000_000_000);
        push_value(1'b1, 32'd4_294_967);
        push_value(1'b0, 32'h5555_5555);
        push_value(1'b1, 32'hAAAA_AAAA);
        wait_drained();

        run_phase(3'd0, 0, 0, 66, 1'b0);
        run_phase(3'd4, 70, 0, 66, 1'b0);
        run_phase(3'd7, 0, 70, 66, 1'b1);
        run_phase(3'd1, 26, 26, 66, 1'b0);
        run_phase(3'd6, 0, 0, 64, 1'b0);
        run_phase(3'd3, 26, 26, 64, 1'b0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Formatted %0d values into %0d characters over %0d fraction settings,",
                 values_accepted, chars_checked, settings_used);
        $display("with sender gaps, receiver stalls and one long output hold-off.");
        if (errors == 0 && expected_chars.size() == 0) begin
            $display("fixed_point_decimal_formatter_top test passed");
        end else begin
            if (expected_chars.size() != 0)
                $display("%0t: %0d expected characters never arrived",
                         $time, expected_chars.size());
            $display("fixed_point_decimal_formatter_top test failed");
        end
        $finish;
    end

endmodule
